// ===== rtl/extent_map_translate_macros.svh =====
// ----------------------------------------------------------------------------
// extent map translator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef EXTENT_MAP_TRANSLATE_MACROS_SVH
`define EXTENT_MAP_TRANSLATE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define EMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emt assertion failed");

// next-cycle implication
`define EMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emt assertion failed");

`else

`define EMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/emt_pkg.sv =====
// ----------------------------------------------------------------------------
// emt_pkg
// operation and status codes and the token that walks the cell chain
// ----------------------------------------------------------------------------
package emt_pkg;

    localparam int VIRT_W = 48;
    localparam int PHYS_W = 48;
    localparam int LEN_W  = 32;

    // operation codes
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_XLATE = 2'd2;
    localparam logic [1:0] KIND_HOLE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMAP = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // virt/phys/len carry the extent being inserted on add;
    // on translate virt is the query, phys/len hold the hit start and offset
    typedef struct packed {
        logic              vld;
        logic [1:0]        kind;
        logic [VIRT_W-1:0] virt;
        logic [PHYS_W-1:0] phys;
        logic [LEN_W-1:0]  len;
        logic              shift;
        logic              done;
        logic [1:0]        status;
        logic [VIRT_W:0]   front;
    } emt_tok_t;

endpackage

// ===== rtl/emt_cell.sv =====
// ----------------------------------------------------------------------------
// emt_cell
// one extent slot; processes the passing token and hands it on
// ----------------------------------------------------------------------------
module emt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              occ,
    input  logic              tail,
    input  emt_pkg::emt_tok_t tin,
    output emt_pkg::emt_tok_t tout
);

    logic [emt_pkg::VIRT_W-1:0] ent_v_reg;
    logic [emt_pkg::VIRT_W-1:0] ent_v_next;
    logic [emt_pkg::PHYS_W-1:0] ent_p_reg;
    logic [emt_pkg::PHYS_W-1:0] ent_p_next;
    logic [emt_pkg::LEN_W-1:0]  ent_l_reg;
    logic [emt_pkg::LEN_W-1:0]  ent_l_next;

    emt_pkg::emt_tok_t tok_reg;
    emt_pkg::emt_tok_t tok_next;
    logic              vld_reg;

    logic                     ent_we;
    logic [emt_pkg::VIRT_W:0] off;
    logic [emt_pkg::VIRT_W:0] end_sum;

    always_comb
    begin
        tok_next = tin;
        ent_we   = 1'b0;
        off      = '0;
        end_sum  = '0;
        if (tin.vld && !tin.done)
        begin
            case (tin.kind)
                emt_pkg::KIND_ADD:
                begin
                    if (occ)
                    begin
                        // past the insert point every entry moves one slot up
                        if (tin.shift || ent_v_reg > tin.virt)
                        begin
                            ent_we         = 1'b1;
                            tok_next.virt  = ent_v_reg;
                            tok_next.phys  = ent_p_reg;
                            tok_next.len   = ent_l_reg;
                            tok_next.shift = 1'b1;
                        end
                    end
                    else if (tail)
                    begin
                        ent_we          = 1'b1;
                        tok_next.done   = 1'b1;
                        tok_next.status = emt_pkg::ST_OK;
                    end
                end
                emt_pkg::KIND_XLATE:
                begin
                    if (occ)
                    begin
                        off = {1'b0, tin.virt} - {1'b0, ent_v_reg};
                        if (tin.virt < ent_v_reg)
                        begin
                            tok_next.done   = 1'b1;
                            tok_next.status = emt_pkg::ST_NOMAP;
                        end
                        else if (off < {{(emt_pkg::VIRT_W + 1 - emt_pkg::LEN_W){1'b0}},
                                        ent_l_reg})
                        begin
                            tok_next.done   = 1'b1;
                            tok_next.status = emt_pkg::ST_OK;
                            tok_next.phys   = ent_p_reg;
                            tok_next.len    = off[emt_pkg::LEN_W-1:0];
                        end
                    end
                end
                emt_pkg::KIND_HOLE:
                begin
                    if (occ)
                    begin
                        end_sum = {1'b0, ent_v_reg}
                                + {{(emt_pkg::VIRT_W + 1 - emt_pkg::LEN_W){1'b0}}, ent_l_reg};
                        if ({1'b0, ent_v_reg} > tin.front)
                        begin
                            tok_next.done   = 1'b1;
                            tok_next.status = emt_pkg::ST_OK;
                        end
                        else if (end_sum > tin.front)
                        begin
                            tok_next.front = end_sum;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ent_v_next = (adv && ent_we) ? tin.virt : ent_v_reg;
    assign ent_p_next = (adv && ent_we) ? tin.phys : ent_p_reg;
    assign ent_l_next = (adv && ent_we) ? tin.len  : ent_l_reg;

    always_ff @(posedge clk)
    begin
        ent_v_reg <= ent_v_next;
        ent_p_reg <= ent_p_next;
        ent_l_reg <= ent_l_next;
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= tok_next.vld;
        end
    end

    always_comb
    begin
        tout     = tok_reg;
        tout.vld = vld_reg;
    end

endmodule

// ===== rtl/extent_map_translate.sv =====
// the token passes every cell register of the chain and then the output register before the result beat is valid
// one item at a time; the token walks the chain one cell a cycle while the result side does not stall
// a new beat can be taken as soon as the previous result sits in the output register
// reset: extent count zero, chain and output register empty; extent slots keep old contents
// ----------------------------------------------------------------------------
// extent_map_translate
// sorted extent table held in a chain of cells; clear, insert, translate and
// first-hole operations ride a token through the chain
// ----------------------------------------------------------------------------
`include "extent_map_translate_macros.svh"

module extent_map_translate #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [47:0] virt_cluster,
    input  logic [47:0] phys_cluster,
    input  logic [31:0] run_length,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [47:0] value
);

    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    // number of occupied slots; slots 0..count-1 hold the table in order
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // one item in flight at a time
    logic busy_reg;
    logic busy_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [47:0] value_reg;
    logic [47:0] value_next;

    emt_pkg::emt_tok_t chain [0:MAX_EXTENTS];
    emt_pkg::emt_tok_t head;
    emt_pkg::emt_tok_t last;

    logic                  accept;
    logic                  adv;
    logic                  load;
    logic                  full;
    logic [MAX_EXTENTS-1:0] occ;
    logic [MAX_EXTENTS-1:0] tail;
    logic [MAX_EXTENTS:0]   vld_vec;
    logic [48:0]           sat_sum;

    assign accept = in_valid && !busy_reg;
    assign full   = (count_reg == CNT_W'(MAX_EXTENTS));
    assign last   = chain[MAX_EXTENTS];

    // the whole chain holds only when the result at the end cannot move out
    assign adv  = !(last.vld && out_valid_reg && out_stall);
    assign load = last.vld && adv;

    // token injected at the head of the chain
    always_comb
    begin
        head.vld    = accept;
        head.kind   = kind;
        head.virt   = virt_cluster;
        head.phys   = phys_cluster;
        head.len    = run_length;
        head.shift  = 1'b0;
        head.front  = '0;
        head.done   = 1'b0;
        head.status = emt_pkg::ST_OK;
        // clear and add-to-full need no walk; they ride through as already done
        if (kind == emt_pkg::KIND_CLEAR)
        begin
            head.done = 1'b1;
        end
        else if (kind == emt_pkg::KIND_ADD && full)
        begin
            head.done   = 1'b1;
            head.status = emt_pkg::ST_FULL;
        end
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++)
        begin : g_cell
            assign occ[gi]  = (CNT_W'(gi) < count_reg);
            assign tail[gi] = (CNT_W'(gi) == count_reg);

            emt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (adv),
                .occ   (occ[gi]),
                .tail  (tail[gi]),
                .tin   (chain[gi]),
                .tout  (chain[gi+1])
            );
        end
        for (gi = 0; gi <= MAX_EXTENTS; gi++)
        begin : g_vld
            assign vld_vec[gi] = chain[gi].vld;
        end
    endgenerate

    // translate hits finish here: physical start plus offset, saturated to 48 bits
    assign sat_sum = {1'b0, last.phys} + {17'b0, last.len};

    always_comb
    begin
        status_next    = status_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
            if (!last.done)
            begin
                // walked off the end of the table
                status_next = emt_pkg::ST_NOMAP;
                value_next  = '0;
            end
            else
            begin
                status_next = last.status;
                value_next  = '0;
                if (last.status == emt_pkg::ST_OK)
                begin
                    case (last.kind)
                        emt_pkg::KIND_XLATE:
                        begin
                            value_next = sat_sum[48] ? '1 : sat_sum[47:0];
                        end
                        emt_pkg::KIND_HOLE:
                        begin
                            value_next = last.front[47:0];
                        end
                        default:
                        begin
                            value_next = '0;
                        end
                    endcase
                end
            end

            // table size changes only once the token has left the chain
            if (last.kind == emt_pkg::KIND_CLEAR)
            begin
                count_next = '0;
            end
            else if (last.kind == emt_pkg::KIND_ADD && last.done
                     && last.status == emt_pkg::ST_OK)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    // an accepted beat blocks the request side until its result is registered
    `EMT_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    // no token inside the cells while idle
    `EMT_ASSERT_IMP(a_idle_empty, clk, rst_n, !busy_reg, vld_vec[MAX_EXTENTS:1] == '0)
    // at most one token in the chain
    `EMT_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(vld_vec))
    // a table-full answer only comes with a full table
    `EMT_ASSERT_IMP(a_full_count, clk, rst_n,
        load && last.done && last.status == emt_pkg::ST_FULL,
        count_reg == CNT_W'(MAX_EXTENTS))
    // a new result only appears for an item in flight
    `EMT_ASSERT_IMP(a_result_busy, clk, rst_n, $rose(out_valid_reg), $past(busy_reg))

endmodule
